// ===== rtl/core/blpg_pkg.sv =====
// Package for the line point generator: widths, kind codes, point type, decision saturation.
package blpg_pkg;

  localparam int COORD_WIDTH    = 10;
  localparam int PT_WIDTH       = COORD_WIDTH + 1;
  localparam int DEC_WIDTH      = COORD_WIDTH + 4;
  localparam int WIDE_WIDTH     = DEC_WIDTH + 2;
  localparam int IN_DATA_WIDTH  = ((4 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = ((2 * PT_WIDTH + 7) / 8) * 8;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef logic [COORD_WIDTH-1:0]        coord_t;
  typedef logic [PT_WIDTH-1:0]           pos_t;
  typedef logic signed [COORD_WIDTH:0]   delta_t;
  typedef logic signed [DEC_WIDTH-1:0]   dec_t;
  typedef logic signed [WIDE_WIDTH-1:0]  wide_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    logic last;
  } point_t;

  localparam wide_t WIDE_DEC_MAX = wide_t'(2 ** (DEC_WIDTH - 1) - 1);
  localparam wide_t WIDE_DEC_MIN = -WIDE_DEC_MAX - wide_t'(1);

  function automatic dec_t sat_dec(input wide_t v);
    dec_t r;
    if (v > WIDE_DEC_MAX) begin
      r = WIDE_DEC_MAX[DEC_WIDTH-1:0];
    end else if (v < WIDE_DEC_MIN) begin
      r = WIDE_DEC_MIN[DEC_WIDTH-1:0];
    end else begin
      r = v[DEC_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/blpg_core.sv =====
// Line state registers and the load and step logic.
module blpg_core import blpg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   kind,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output logic   res_valid,
  output point_t res,
  input  logic   res_ready
);

  pos_t                   cur_x;
  pos_t                   cur_y;
  dec_t                   decision;
  delta_t                 minor_delta;
  delta_t                 major_delta;
  logic                   major_is_y;
  logic [COORD_WIDTH-1:0] points_left;

  logic   fire;
  logic   load;
  logic   step;
  delta_t dx;
  delta_t dy;
  logic   y_major;
  delta_t major_ld;
  delta_t minor_ld;
  dec_t   decision_ld;
  logic   dec_le0;
  wide_t  inc;
  dec_t   decision_step;

  assign in_ready = res_ready;
  assign fire     = in_valid && in_ready;
  assign load     = fire && (kind == KIND_START);
  assign step     = fire && (kind == KIND_STEP) && (points_left != '0);

  assign dx       = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
  assign dy       = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
  assign y_major  = (dy >= dx);
  assign major_ld = y_major ? dy : dx;
  assign minor_ld = y_major ? dx : dy;
  assign decision_ld = sat_dec((wide_t'(minor_ld) <<< 1) - wide_t'(major_ld));

  assign dec_le0 = (decision <= 0);
  assign inc     = dec_le0 ? (wide_t'(minor_delta) <<< 1)
                           : ((wide_t'(minor_delta) <<< 1) - (wide_t'(major_delta) <<< 1));
  assign decision_step = sat_dec(wide_t'(decision) + inc);

  assign res_valid = step;
  assign res.x     = cur_x;
  assign res.y     = cur_y;
  assign res.last  = (points_left == COORD_WIDTH'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      decision    <= '0;
      minor_delta <= '0;
      major_delta <= '0;
      major_is_y  <= 1'b0;
      points_left <= '0;
    end else if (load) begin
      cur_x       <= PT_WIDTH'(start_x);
      cur_y       <= PT_WIDTH'(start_y);
      decision    <= decision_ld;
      minor_delta <= minor_ld;
      major_delta <= major_ld;
      major_is_y  <= y_major;
      points_left <= (major_ld > 0) ? major_ld[COORD_WIDTH-1:0] : '0;
    end else if (step) begin
      decision    <= decision_step;
      points_left <= points_left - COORD_WIDTH'(1);
      if (!dec_le0 || !major_is_y) begin
        cur_x <= cur_x + PT_WIDTH'(1);
      end
      if (!dec_le0 || major_is_y) begin
        cur_y <= cur_y + PT_WIDTH'(1);
      end
    end
  end

  a_minor_le_major: assert property (@(posedge clk) disable iff (rst)
    minor_delta <= major_delta)
    else $error("minor delta exceeds major delta");

  a_active_has_major: assert property (@(posedge clk) disable iff (rst)
    (points_left != '0) |-> (major_delta > 0))
    else $error("points remain on a line with no positive major delta");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (step && res.last) |=> (points_left == '0))
    else $error("points remain after the last point");

endmodule

// ===== rtl/core/blpg_skid.sv =====
// Output register with a skid stage for the point stream.
module blpg_skid import blpg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  point_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output point_t out_data
);

  point_t main_data;
  point_t skid_data;
  logic   main_valid;
  logic   skid_valid;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !main_valid) begin
      main_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held with empty output register");

endmodule

// ===== rtl/core/bresenham_line_point_generator.sv =====
// Top level of the line point generator: stream ports, line state and output buffer.
//
//  channel   dir  tdata (low bit up)                      tuser   tlast
//  s_axis    in   start_x, start_y, end_x, end_y          kind    -
//  m_axis    out  point_x, point_y                        -       last_point
//
//  One input transfer per cycle while the skid stage is empty. Unless the output
//  stalls, a step loads its point into the output register at its accepting edge,
//  so the point is offered in the following cycle. A start transfer loads the line
//  and yields no point. Reset (rst, synchronous) clears the line: steps give no
//  point until a start. The skid stage takes one more point while the output
//  stalls; input then stalls until the stage drains.
module bresenham_line_point_generator import blpg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,  // start_x, start_y, end_x, end_y
  input  logic                      s_axis_tuser,  // kind
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata,  // point_x, point_y
  output logic                      m_axis_tlast   // last_point
);

  logic   res_valid;
  logic   res_ready;
  point_t res;
  point_t out_pt;

  blpg_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .kind      (s_axis_tuser),
    .start_x   (s_axis_tdata[COORD_WIDTH-1:0]),
    .start_y   (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .end_x     (s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .end_y     (s_axis_tdata[4*COORD_WIDTH-1:3*COORD_WIDTH]),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  blpg_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_pt)
  );

  assign m_axis_tdata = OUT_DATA_WIDTH'({out_pt.y, out_pt.x});
  assign m_axis_tlast = out_pt.last;

endmodule
